[hw/rtl/sfpda_pkg.sv]
`timescale 1ns / 1ps

package sfpda_pkg;

    localparam int BIN_WIDTH  = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_WIDTH  = NUM_DIGITS * 4;
    localparam int CHAR_WIDTH = 6;

    localparam logic [3:0] MAX_PLACES = 4'd9;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_POINT = 6'd46;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

    typedef struct packed {
        logic signed [BIN_WIDTH-1:0] value;
        logic [3:0]                  decimal_places;
    } number_item_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_code;
        logic                  last;
    } text_item_t;

endpackage

[hw/rtl/stream_if.sv]
`timescale 1ns / 1ps

interface stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/signed_fixed_point_to_decimal_ascii_top.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Payload                               | Handshake
// number   | in        | value (s32), decimal_places (u4)      | valid/ready
// text     | out       | char_code (u6), last (u1)             | valid/ready
//
// One number is converted in one load, 32 shift-and-correct steps of the
// shared BCD adjust unit and one digit-count step, then emitted at one
// character per cycle, 1 to 12 characters, when text is not stalled.
// number.ready is high only while no number is in work.
// Reset clears the sequencer and the output valid; data registers are not reset.
// A stall on text holds the character register and pauses emission.

module signed_fixed_point_to_decimal_ascii_top (
    input  logic                   clk,
    input  logic                   rst_n,
    stream_if.sink                 number,
    stream_if.source               text
);
    import sfpda_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIZE = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [4:0]            step_reg, step_next;
    logic [BIN_WIDTH-1:0]  bin_reg, bin_next;
    logic [BCD_WIDTH-1:0]  bcd_reg, bcd_next;
    logic [3:0]            places_reg, places_next;
    logic                  neg_reg, neg_next;
    logic [3:0]            pos_reg, pos_next;
    logic                  dot_done_reg, dot_done_next;
    logic                  out_valid_reg, out_valid_next;
    text_item_t            out_data_reg, out_data_next;

    logic [BCD_WIDTH-1:0]  bcd_adj;
    logic [3:0]            sig_cnt;
    logic [3:0]            total_cnt;
    logic [3:0]            cur_digit;
    logic                  out_free;
    logic                  accept;

    assign number.ready = (state_reg == ST_IDLE);
    assign accept       = number.valid && number.ready;
    assign out_free     = !out_valid_reg || text.ready;
    assign text.valid   = out_valid_reg;
    assign text.data    = out_data_reg;

    // Shared adjust unit: add three to every BCD digit of five or more.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // Count significant digits, at least one, and the digits to emit: at least places plus one when places is nonzero.
    always_comb
    begin
        sig_cnt = 4'd1;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
                sig_cnt = 4'(i + 1);
        end
        if (places_reg != 4'd0 && sig_cnt < places_reg + 4'd1)
            total_cnt = places_reg + 4'd1;
        else
            total_cnt = sig_cnt;
    end

    always_comb
    begin
        cur_digit = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (pos_reg == 4'(i + 1))
                cur_digit = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        places_next    = places_reg;
        neg_next       = neg_reg;
        pos_next       = pos_reg;
        dot_done_next  = dot_done_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (text.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next = number.data.value[BIN_WIDTH-1];
                    if (number.data.value[BIN_WIDTH-1])
                        bin_next = 32'd0 - number.data.value;
                    else
                        bin_next = number.data.value;
                    if (number.data.decimal_places > MAX_PLACES)
                        places_next = MAX_PLACES;
                    else
                        places_next = number.data.decimal_places;
                    bcd_next      = '0;
                    step_next     = '0;
                    dot_done_next = 1'b0;
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                {bcd_next, bin_next} = {bcd_adj[BCD_WIDTH-2:0], bin_reg, 1'b0};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(BIN_WIDTH - 1))
                    state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                pos_next = total_cnt;
                if (neg_reg)
                    state_next = ST_SIGN;
                else
                    state_next = ST_EMIT;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.char_code = CHAR_MINUS;
                    out_data_next.last      = 1'b0;
                    state_next              = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (places_reg != 4'd0 && pos_reg == places_reg && !dot_done_reg)
                    begin
                        out_data_next.char_code = CHAR_POINT;
                        out_data_next.last      = 1'b0;
                        dot_done_next           = 1'b1;
                    end
                    else
                    begin
                        out_data_next.char_code = CHAR_ZERO + {2'b00, cur_digit};
                        out_data_next.last      = (pos_reg == 4'd1);
                        pos_next                = pos_reg - 4'd1;
                        if (pos_reg == 4'd1)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pos_reg       <= '0;
            dot_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            dot_done_reg  <= dot_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        places_reg   <= places_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

endmodule

[hw/rtl/sfpda_check.sv]
`timescale 1ns / 1ps

module sfpda_check (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [sfpda_pkg::CHAR_WIDTH-1:0] out_char,
    input logic                           out_last
);
    import sfpda_pkg::*;

    // Busy after a request is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after accepting a number");

    // Ready returns only once the final character is on the output.
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && $rose(in_ready)) |-> (out_valid && out_last))
        else $error("input ready without the final character shown");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char == CHAR_MINUS || out_char == CHAR_POINT ||
                       (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 6'd9)))
        else $error("illegal character code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_char) && $stable(out_last)))
        else $error("stalled character changed");

endmodule

bind signed_fixed_point_to_decimal_ascii_top sfpda_check u_sfpda_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.data.char_code),
    .out_last  (text.data.last)
);
